@@ hdl/two_source_pcm_mixer_limiter_top_macros.svh @@
// ----------------------------------------------------------------------------
// Two-source PCM mixer: assertion macros
// Shorthand for clocked implications, sampled on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef TWO_SOURCE_PCM_MIXER_LIMITER_TOP_MACROS_SVH
`define TWO_SOURCE_PCM_MIXER_LIMITER_TOP_MACROS_SVH

// Same-cycle implication
`define TSML_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TSML_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/tsml_pkg.sv @@
// ----------------------------------------------------------------------------
// Two-source PCM mixer: shared package
// Widths, limits, register map and the beat types of the mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package tsml_pkg;

  localparam int SampleBits  = 16;
  localparam int GainBits    = 16;
  localparam int GainFrac    = 12;
  localparam int FactorFrac  = 16;
  localparam int DecayShift  = 5;

  // signed sample times unsigned gain
  localparam int ProdBits    = SampleBits + GainBits;
  // one gained sample clamped to the Q12 limit
  localparam int ClampBits   = SampleBits + GainFrac + 1;
  localparam int SumBits     = ClampBits + 1;
  localparam int TruncBits   = SumBits - GainFrac;
  localparam int FactorBits  = FactorFrac + 1;
  localparam int ScaledBits  = SumBits + FactorBits;
  localparam int RightBits   = ScaledBits - GainFrac - FactorFrac;

  localparam int DivStages   = 4;
  localparam int DivSteps    = FactorFrac / DivStages;

  localparam logic signed [SampleBits-1:0] LimitS =
    {1'b0, {(SampleBits-1){1'b1}}};
  localparam logic signed [SampleBits-1:0] NegLimitS = -LimitS;
  localparam logic [SampleBits-1:0] SampleMin = {1'b1, {(SampleBits-1){1'b0}}};

  localparam logic signed [ClampBits-1:0] LimitQ =
    {2'b00, {(SampleBits-1){1'b1}}, {GainFrac{1'b0}}};
  localparam logic signed [ClampBits-1:0] NegLimitQ = -LimitQ;

  localparam logic signed [TruncBits-1:0] LimitT =
    {{(TruncBits-SampleBits+1){1'b0}}, {(SampleBits-1){1'b1}}};
  localparam logic signed [TruncBits-1:0] NegLimitT = -LimitT;

  localparam logic signed [RightBits-1:0] LimitR =
    {{(RightBits-SampleBits+1){1'b0}}, {(SampleBits-1){1'b1}}};
  localparam logic signed [RightBits-1:0] NegLimitR = -LimitR;

  localparam logic [FactorBits-1:0] FactorOne = {1'b1, {FactorFrac{1'b0}}};

  // channel modes
  localparam logic [1:0] ChanMono   = 2'd1;
  localparam logic [1:0] ChanStereo = 2'd2;

  // register map
  localparam int RegCount = 3;
  localparam int AddrBits = $clog2(4 * RegCount);
  localparam int IdxBits  = AddrBits - 2;
  localparam int DataBits = 32;
  localparam logic [IdxBits-1:0] RegChannelCount   = 2'd0;
  localparam logic [IdxBits-1:0] RegBackgroundGain = 2'd1;
  localparam logic [IdxBits-1:0] RegVoiceGain      = 2'd2;

  localparam logic [1:0]          ChanReset       = ChanStereo;
  localparam logic [GainBits-1:0] BackgroundReset = 16'd2048;
  localparam logic [GainBits-1:0] VoiceReset      = 16'd10240;

  typedef struct packed {
    logic signed [SampleBits-1:0] background_left;
    logic signed [SampleBits-1:0] background_right;
    logic signed [SampleBits-1:0] voice_left;
    logic signed [SampleBits-1:0] voice_right;
  } in_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] mix_left;
    logic signed [SampleBits-1:0] mix_right;
  } out_t;

  typedef struct packed {
    logic [1:0]          chan;
    logic [GainBits-1:0] background_gain;
    logic [GainBits-1:0] voice_gain;
  } cfg_t;

  // what travels alongside the divider
  typedef struct packed {
    logic [1:0]                   chan;
    logic                         over;
    logic signed [SampleBits-1:0] left;
    logic signed [SumBits-1:0]    rsum;
  } side_t;

endpackage

`default_nettype wire

@@ hdl/tsml_front.sv @@
// ----------------------------------------------------------------------------
// Two-source PCM mixer: gain and sum front end
// Three stages: gain products, clamp and channel sums, left truncation and
// limiter detection.
// ----------------------------------------------------------------------------
`default_nettype none

module tsml_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  tsml_pkg::in_t                       data_i,
  input  tsml_pkg::cfg_t                      cfg_i,
  output logic                                valid_o,
  output logic [tsml_pkg::SampleBits-1:0]     mag_o,
  output tsml_pkg::side_t                     side_o
);

  localparam int SB = tsml_pkg::SampleBits;
  localparam int PB = tsml_pkg::ProdBits;
  localparam int CB = tsml_pkg::ClampBits;
  localparam int MB = tsml_pkg::SumBits;
  localparam int TB = tsml_pkg::TruncBits;
  localparam int GF = tsml_pkg::GainFrac;

  function automatic logic signed [CB-1:0] clamp_q(input logic signed [PB:0] x);
    logic signed [CB-1:0] r;
    if (x > tsml_pkg::LimitQ) begin
      r = tsml_pkg::LimitQ;
    end else if (x < tsml_pkg::NegLimitQ) begin
      r = tsml_pkg::NegLimitQ;
    end else begin
      r = x[CB-1:0];
    end
    return r;
  endfunction

  // ---- stage 1: products
  logic signed [PB:0]   pbl_w, pbr_w, pvl_w, pvr_w;
  logic                 v1_q;
  logic [1:0]           chan1_q;
  logic signed [PB-1:0] pbl_q, pbr_q, pvl_q, pvr_q;

  assign pbl_w = data_i.background_left  * $signed({1'b0, cfg_i.background_gain});
  assign pbr_w = data_i.background_right * $signed({1'b0, cfg_i.background_gain});
  assign pvl_w = data_i.voice_left       * $signed({1'b0, cfg_i.voice_gain});
  assign pvr_w = data_i.voice_right      * $signed({1'b0, cfg_i.voice_gain});

  // ---- stage 2: clamp and sum
  logic signed [PB:0]   mono_sum;
  logic signed [CB-1:0] bl_c, br_c, vl_c, vr_c, mono_c;
  logic signed [MB-1:0] lsum_d, rsum_d;
  logic                 v2_q;
  logic [1:0]           chan2_q;
  logic signed [MB-1:0] lsum_q, rsum_q;

  assign mono_sum = $signed({pbl_q[PB-1], pbl_q}) + $signed({pvl_q[PB-1], pvl_q});
  assign mono_c   = clamp_q(mono_sum);
  assign bl_c     = clamp_q($signed({pbl_q[PB-1], pbl_q}));
  assign br_c     = clamp_q($signed({pbr_q[PB-1], pbr_q}));
  assign vl_c     = clamp_q($signed({pvl_q[PB-1], pvl_q}));
  assign vr_c     = clamp_q($signed({pvr_q[PB-1], pvr_q}));

  // mono reuses the left path: a clamped mono sum never trips the limiter
  assign lsum_d = (chan1_q == tsml_pkg::ChanMono) ?
                  $signed({mono_c[CB-1], mono_c}) :
                  $signed({bl_c[CB-1], bl_c}) + $signed({vl_c[CB-1], vl_c});
  assign rsum_d = $signed({br_c[CB-1], br_c}) + $signed({vr_c[CB-1], vr_c});

  // ---- stage 3: truncate left toward zero, detect limiting
  logic signed [MB-1:0] lbias;
  logic signed [TB-1:0] ltr;
  logic [TB-1:0]        labs;
  logic                 over;
  logic signed [SB-1:0] left_d;
  logic                 v3_q;
  logic [SB-1:0]        mag3_q;
  tsml_pkg::side_t      side3_q;

  assign lbias = lsum_q + $signed({{(MB-GF){1'b0}}, {GF{lsum_q[MB-1]}}});
  assign ltr   = lbias[MB-1:GF];
  assign labs  = ltr[TB-1] ? -ltr : ltr;
  assign over  = (ltr > tsml_pkg::LimitT) || (ltr < tsml_pkg::NegLimitT);

  always_comb begin
    if (!over) begin
      left_d = ltr[SB-1:0];
    end else if (ltr[TB-1]) begin
      left_d = tsml_pkg::NegLimitS;
    end else begin
      left_d = tsml_pkg::LimitS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      chan1_q      <= cfg_i.chan;
      pbl_q        <= pbl_w[PB-1:0];
      pbr_q        <= pbr_w[PB-1:0];
      pvl_q        <= pvl_w[PB-1:0];
      pvr_q        <= pvr_w[PB-1:0];
      chan2_q      <= chan1_q;
      lsum_q       <= lsum_d;
      rsum_q       <= rsum_d;
      mag3_q       <= labs[SB-1:0];
      side3_q.chan <= chan2_q;
      side3_q.over <= over;
      side3_q.left <= left_d;
      side3_q.rsum <= rsum_q;
    end
  end

  assign valid_o = v3_q;
  assign mag_o   = mag3_q;
  assign side_o  = side3_q;

endmodule

`default_nettype wire

@@ hdl/tsml_div.sv @@
// ----------------------------------------------------------------------------
// Two-source PCM mixer: limiter reciprocal
// Pipelined restoring divider for floor((LIMIT << 16) / mag), a few quotient
// bits per stage. The quotient fits 16 bits when mag > LIMIT, the only case that uses it.
// ----------------------------------------------------------------------------
`default_nettype none

module tsml_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [tsml_pkg::SampleBits-1:0]     mag_i,
  input  tsml_pkg::side_t                     side_i,
  output logic                                valid_o,
  output logic [tsml_pkg::FactorFrac-1:0]     quot_o,
  output tsml_pkg::side_t                     side_o
);

  localparam int SB = tsml_pkg::SampleBits;
  localparam int QB = tsml_pkg::FactorFrac;
  localparam int NS = tsml_pkg::DivStages;
  localparam int KS = tsml_pkg::DivSteps;

  logic            v_q    [NS];
  logic [SB-1:0]   rem_q  [NS];
  logic [SB-1:0]   mag_q  [NS];
  logic [QB-1:0]   quot_q [NS];
  tsml_pkg::side_t side_q [NS];

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic            v_in;
    logic [SB-1:0]   rem_in, mag_in;
    logic [QB-1:0]   quot_in;
    tsml_pkg::side_t side_in;
    logic [SB-1:0]   rem_d;
    logic [QB-1:0]   quot_d;

    if (g == 0) begin : g_first
      // low dividend bits are zero, so the partial remainder starts at LIMIT
      assign v_in    = valid_i;
      assign rem_in  = tsml_pkg::LimitS;
      assign mag_in  = mag_i;
      assign quot_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign mag_in  = mag_q[g-1];
      assign quot_in = quot_q[g-1];
      assign side_in = side_q[g-1];
    end

    always_comb begin
      logic [SB:0] shifted;
      rem_d  = rem_in;
      quot_d = quot_in;
      for (int k = 0; k < KS; k++) begin
        shifted = {rem_d, 1'b0};
        if (shifted >= {1'b0, mag_in}) begin
          shifted = shifted - {1'b0, mag_in};
          quot_d  = {quot_d[QB-2:0], 1'b1};
        end else begin
          quot_d  = {quot_d[QB-2:0], 1'b0};
        end
        rem_d = shifted[SB-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_d;
        mag_q[g]  <= mag_in;
        quot_q[g] <= quot_d;
        side_q[g] <= side_in;
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign quot_o  = quot_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

`default_nettype wire

@@ hdl/tsml_scale.sv @@
// ----------------------------------------------------------------------------
// Two-source PCM mixer: right-channel scaling
// Eases the factor back toward one, scales the right sum with a split
// multiply, truncates, clamps and forms the output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tsml_scale (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [tsml_pkg::FactorFrac-1:0]     quot_i,
  input  tsml_pkg::side_t                     side_i,
  output logic                                valid_o,
  output tsml_pkg::out_t                      data_o
);

  localparam int SB  = tsml_pkg::SampleBits;
  localparam int MB  = tsml_pkg::SumBits;
  localparam int FB  = tsml_pkg::FactorBits;
  localparam int XB  = tsml_pkg::ScaledBits;
  localparam int RB  = tsml_pkg::RightBits;
  localparam int LoB = FB / 2;
  localparam int HiB = FB - LoB;
  localparam int PpB = MB + HiB + 1;
  localparam int WB  = PpB + LoB;
  localparam int TF  = tsml_pkg::GainFrac + tsml_pkg::FactorFrac;

  // ---- stage A: factor
  logic [FB-1:0]   quot_x, fac_d;
  logic            va_q;
  logic [FB-1:0]   fac_q;
  tsml_pkg::side_t sa_q;

  assign quot_x = {1'b0, quot_i};
  assign fac_d  = side_i.over ?
                  quot_x + ((tsml_pkg::FactorOne - quot_x) >> tsml_pkg::DecayShift) :
                  tsml_pkg::FactorOne;

  // ---- stage B: two partial products
  logic signed [PpB-1:0] ppl_d, pph_d;
  logic                  vb_q;
  logic signed [PpB-1:0] ppl_q, pph_q;
  tsml_pkg::side_t       sb_q;

  assign ppl_d = sa_q.rsum * $signed({1'b0, fac_q[LoB-1:0]});
  assign pph_d = sa_q.rsum * $signed({1'b0, fac_q[FB-1:LoB]});

  // ---- stage C: combine
  logic signed [WB-1:0] prod_w;
  logic                 vc_q;
  logic signed [XB-1:0] prod_q;
  tsml_pkg::side_t      sc_q;

  assign prod_w = $signed({pph_q, {LoB{1'b0}}}) +
                  $signed({{LoB{ppl_q[PpB-1]}}, ppl_q});

  // ---- stage D: truncate Q28 toward zero
  logic signed [XB-1:0] rbias;
  logic                 vd_q;
  logic signed [RB-1:0] rtr_q;
  tsml_pkg::side_t      sd_q;

  assign rbias = prod_q + $signed({{(XB-TF){1'b0}}, {TF{prod_q[XB-1]}}});

  // ---- stage E: clamp and select by mode
  logic signed [SB-1:0] right_c;
  tsml_pkg::out_t       out_d;
  logic                 ve_q;
  tsml_pkg::out_t       out_q;

  always_comb begin
    if (rtr_q > tsml_pkg::LimitR) begin
      right_c = tsml_pkg::LimitS;
    end else if (rtr_q < tsml_pkg::NegLimitR) begin
      right_c = tsml_pkg::NegLimitS;
    end else begin
      right_c = rtr_q[SB-1:0];
    end
  end

  always_comb begin
    out_d = '0;
    case (sd_q.chan)
      tsml_pkg::ChanMono: begin
        out_d.mix_left = sd_q.left;
      end
      tsml_pkg::ChanStereo: begin
        out_d.mix_left  = sd_q.left;
        out_d.mix_right = right_c;
      end
      default: begin
        out_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fac_q  <= fac_d;
      sa_q   <= side_i;
      ppl_q  <= ppl_d;
      pph_q  <= pph_d;
      sb_q   <= sa_q;
      prod_q <= prod_w[XB-1:0];
      sc_q   <= sb_q;
      rtr_q  <= rbias[XB-1:TF];
      sd_q   <= sc_q;
      out_q  <= out_d;
    end
  end

  assign valid_o = ve_q;
  assign data_o  = out_q;

endmodule

`default_nettype wire

@@ hdl/two_source_pcm_mixer_limiter_top.sv @@
// ----------------------------------------------------------------------------
// Two-source PCM mixer with gain and limiter: top level
// Register block, twelve-stage mixing pipeline and output skid buffer.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Beat
//  --------+-----------+----------------------+-------------------------------
//  in      | sink      | in_valid_i/in_stall_o | in_data_i  (tsml_pkg::in_t)
//  out     | source    | out_valid_o/out_stall_i | out_data_o (tsml_pkg::out_t)
//  cfg     | APB slave | psel/penable/pready  | paddr, pwdata, prdata
//
// One frame per clock sustained while the output is not stalled.
// The pipeline depth comes from the pipelined reciprocal divider (four quotient bits per
// stage) and the split right-channel multiply.
// Reset restores the register defaults and empties pipeline and skid.
// A stalled output fills the skid; in_stall_o is high only while it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module two_source_pcm_mixer_limiter_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  tsml_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output tsml_pkg::out_t                    out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tsml_pkg::AddrBits-1:0]     paddr,
  input  logic [tsml_pkg::DataBits-1:0]     pwdata,
  output logic [tsml_pkg::DataBits-1:0]     prdata,
  output logic                              pready
);

  localparam int AB = tsml_pkg::AddrBits;
  localparam int DB = tsml_pkg::DataBits;
  localparam int GB = tsml_pkg::GainBits;

  // ---- registers
  logic [1:0]    chan_q;
  logic [GB-1:0] bg_gain_q, vo_gain_q;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q    <= tsml_pkg::ChanReset;
      bg_gain_q <= tsml_pkg::BackgroundReset;
      vo_gain_q <= tsml_pkg::VoiceReset;
    end else if (wr_en) begin
      unique case (paddr[AB-1:2])
        tsml_pkg::RegChannelCount:   chan_q    <= pwdata[1:0];
        tsml_pkg::RegBackgroundGain: bg_gain_q <= pwdata[GB-1:0];
        tsml_pkg::RegVoiceGain:      vo_gain_q <= pwdata[GB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[AB-1:2])
      tsml_pkg::RegChannelCount:   prdata = {{(DB-2){1'b0}}, chan_q};
      tsml_pkg::RegBackgroundGain: prdata = {{(DB-GB){1'b0}}, bg_gain_q};
      tsml_pkg::RegVoiceGain:      prdata = {{(DB-GB){1'b0}}, vo_gain_q};
      default:                     prdata = '0;
    endcase
  end

  // ---- pipeline
  tsml_pkg::cfg_t  cfg;
  logic            pipe_en;
  logic            v_front, v_div, v_pipe;
  logic [tsml_pkg::SampleBits-1:0] mag_front;
  logic [tsml_pkg::FactorFrac-1:0] quot_div;
  tsml_pkg::side_t side_front, side_div;
  tsml_pkg::out_t  data_pipe;

  logic           out_v_q, skid_v_q;
  tsml_pkg::out_t out_q, skid_q;

  assign cfg.chan            = chan_q;
  assign cfg.background_gain = bg_gain_q;
  assign cfg.voice_gain      = vo_gain_q;

  // the whole pipeline holds only while the skid is occupied
  assign pipe_en    = !skid_v_q;
  assign in_stall_o = skid_v_q;

  tsml_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .cfg_i   (cfg),
    .valid_o (v_front),
    .mag_o   (mag_front),
    .side_o  (side_front)
  );

  tsml_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (v_front),
    .mag_i   (mag_front),
    .side_i  (side_front),
    .valid_o (v_div),
    .quot_o  (quot_div),
    .side_o  (side_div)
  );

  tsml_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (v_div),
    .quot_i  (quot_div),
    .side_i  (side_div),
    .valid_o (v_pipe),
    .data_o  (data_pipe)
  );

  // ---- output register and skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_v_q && out_stall_i) begin
      if (v_pipe && !skid_v_q) begin
        skid_v_q <= 1'b1;
      end
    end else if (skid_v_q) begin
      out_v_q  <= 1'b1;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= v_pipe;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_v_q && out_stall_i) begin
      if (!skid_v_q) begin
        skid_q <= data_pipe;
      end
    end else if (skid_v_q) begin
      out_q <= skid_q;
    end else begin
      out_q <= data_pipe;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ hdl/tsml_checker.sv @@
// ----------------------------------------------------------------------------
// Two-source PCM mixer: port checker
// Watches the top-level ports for output hold, sample range and skid use.
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_source_pcm_mixer_limiter_top_macros.svh"

module tsml_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input tsml_pkg::out_t out_data_o
);

  `TSML_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "output beat dropped or changed while stalled")

  `TSML_ASSERT_IMPL(a_left_range, out_valid_o, out_data_o.mix_left != tsml_pkg::SampleMin, "left sample outside the clamp range")

  `TSML_ASSERT_IMPL(a_right_range, out_valid_o, out_data_o.mix_right != tsml_pkg::SampleMin, "right sample outside the clamp range")

  // the skid only fills behind a stalled output beat and drains once that stall lifts
  `TSML_ASSERT_IMPL(a_skid_cause, in_stall_o, out_valid_o && $past(out_stall_i), "input stalled without a stalled output")

endmodule

bind two_source_pcm_mixer_limiter_top tsml_checker u_checker (.*);

`default_nettype wire
